// File: rtl/bwsf_pkg.sv
// Package: shared constants, command and status codes for the banned word filter.
package bwsf_pkg;
  localparam int NUM_WORDS_D    = 64;
  localparam int MAX_WORD_LEN_D = 16;
  localparam int MAX_TEXT_LEN_D = 1024;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TEXT  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_BANNED   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_WORD_BIG = 3'd5;

  // Controls broadcast from the sequencer to every word cell.
  typedef struct packed {
    logic       text_step;   // shift a text byte past the cells
    logic       load_byte;   // store a byte into the selected cell
    logic       commit;      // word committed in the selected cell
    logic       clear_hits;  // drop all match flags
    logic       tag;         // list tag for the committed word
  } bwsf_ctl_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] b);
    if (b >= 8'h61 && b <= 8'h7A) return b - 8'h20;
    return b;
  endfunction
endpackage

// File: rtl/bwsf_cell.sv
// Word cell: one stored word, its own byte window compare and hit flag.
module bwsf_cell import bwsf_pkg::*; #(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_D,
  localparam int PW = $clog2(MAX_WORD_LEN + 1),
  localparam int LW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bwsf_ctl_t                   ctl,
  input  logic                        sel,
  input  logic [LW-1:0]               load_pos,
  input  logic [7:0]                  load_data,
  input  logic [PW-1:0]               commit_len,
  input  logic [MAX_WORD_LEN*8-1:0]   window,    // newest byte lowest
  input  logic [PW-1:0]               text_len,  // saturated at MAX_WORD_LEN
  output logic                        hit,
  output logic                        empty,
  output logic                        tag
);
  logic [7:0]    bytes_r [MAX_WORD_LEN];
  logic [PW-1:0] len_r;
  logic          tag_r, hit_r, hit_nxt, same;

  always_ff @(posedge clk) begin
    if (ctl.load_byte && sel) bytes_r[load_pos] <= load_data;
    if (ctl.commit && sel) begin
      len_r <= commit_len;
      tag_r <= ctl.tag;
    end
  end

  // Byte k of the word sits len-1-k bytes back in the window.
  always_comb begin
    same = (len_r != '0) && (len_r <= text_len);
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      if (PW'(k) < len_r &&
          bytes_r[k] != window[(int'(len_r) - 1 - k) * 8 +: 8]) same = 1'b0;
    end
    hit_nxt = hit_r;
    // A freshly committed word starts with no hit.
    if (ctl.clear_hits || (ctl.commit && sel)) hit_nxt = 1'b0;
    else if (ctl.text_step && same) hit_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hit_r <= 1'b0;
    else        hit_r <= hit_nxt;
  end

  assign hit   = hit_r;
  assign empty = (len_r == '0);
  assign tag   = tag_r;
endmodule

// File: rtl/banned_word_substring_filter.sv
// Top level: banned word substring filter with a row of word cells.
//
//  channel | dir | fields (tdata low bit up)                          | extra
//  in_     | in  | byte_value[7:0], last_of_word[8], word_list[9]     | tuser=command
//  out_    | out | status[2:0], word_index[8:3]                       | tuser=result_kind
//  cfg_    | in  | lists_checked[1:0]                                 | we only
//
// A word cell per stored word compares its word against the text window as each
// byte shifts in. An end-of-text beat then scans the cells, one cell a cycle.
// Synchronous active-low reset empties the table and text; no clearing pass.
// A pending result holds in the output register until taken; input stalls then.
module banned_word_substring_filter import bwsf_pkg::*; #(
  parameter int NUM_WORDS    = NUM_WORDS_D,
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_D,
  parameter int MAX_TEXT_LEN = MAX_TEXT_LEN_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // byte_value, last_of_word, word_list, zero fill
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status, word_index, zero fill
  output logic        out_tuser,  // result_kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata   // lists_checked
);
  localparam int PW = $clog2(MAX_WORD_LEN + 1);
  localparam int LW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int CW = $clog2(NUM_WORDS + 1);
  localparam int IW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int TW = $clog2(MAX_TEXT_LEN + 1);

  typedef enum logic [1:0] {S_RUN = 2'b01, S_SCAN = 2'b10} state_t;

  state_t                    state_r, state_nxt;
  logic [1:0]                lists_r;
  logic [CW-1:0]             count_r, count_nxt;
  logic [PW-1:0]             pos_r, pos_nxt, zlen_r, zlen_nxt;
  logic                      ovf_r, ovf_nxt, zseen_r, zseen_nxt;
  logic [MAX_WORD_LEN*8-1:0] win_r, win_nxt;
  logic [TW-1:0]             tcnt_r, tcnt_nxt;
  logic [CW-1:0]             scan_r, scan_nxt;
  logic                      ov_r, ov_nxt, okind_r, okind_nxt;
  logic [2:0]                ost_r, ost_nxt;
  logic [5:0]                oidx_r, oidx_nxt;
  bwsf_ctl_t                 ctl;
  logic [NUM_WORDS-1:0]      hit, empty, tagv;
  logic                      acc, full, ok_pos;
  logic [1:0]                cmd;
  logic [7:0]                b;
  logic [IW-1:0]             sidx;
  logic [PW-1:0]             word_len;
  logic                      word_ovf;

  assign cmd    = in_tuser;
  assign b      = in_tdata[7:0];
  assign full   = (count_r >= CW'(NUM_WORDS));
  assign ok_pos = (pos_r < PW'(MAX_WORD_LEN));
  assign in_tready = (state_r == S_RUN) && !ov_r;
  assign acc    = in_tvalid && in_tready;
  assign sidx   = scan_r[IW-1:0];
  // Word overflows once a byte arrives with every slot byte taken.
  assign word_ovf = ovf_r || !ok_pos;

  // Cell controls: sel picks the slot being filled.
  always_comb begin
    ctl.text_step  = acc && cmd == CMD_TEXT;
    ctl.load_byte  = acc && cmd == CMD_LOAD && !full && ok_pos;
    ctl.commit     = acc && cmd == CMD_LOAD && in_tdata[8] && !full && !word_ovf;
    ctl.clear_hits = (acc && cmd == CMD_CLEAR) || (state_r == S_SCAN && state_nxt == S_RUN);
    ctl.tag        = in_tdata[9];
  end

  // Length up to the first zero byte, counting the byte of this beat.
  assign word_len = (ctl.load_byte && b != 8'd0 && !zseen_r) ? pos_r + PW'(1) : zlen_r;

  for (genvar g = 0; g < NUM_WORDS; g++) begin : g_cell
    bwsf_cell #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_cell (
      .clk, .rst_n, .ctl,
      .sel(count_r == CW'(g)),
      .load_pos(pos_r[LW-1:0]),
      .load_data(b),
      .commit_len(word_len),
      .window(win_nxt),
      .text_len((tcnt_nxt >= TW'(MAX_WORD_LEN)) ? PW'(MAX_WORD_LEN) : PW'(tcnt_nxt)),
      .hit(hit[g]), .empty(empty[g]), .tag(tagv[g])
    );
  end

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; pos_nxt = pos_r; ovf_nxt = ovf_r;
    zlen_nxt = zlen_r; zseen_nxt = zseen_r; win_nxt = win_r; tcnt_nxt = tcnt_r;
    scan_nxt = scan_r; ov_nxt = ov_r; okind_nxt = okind_r; ost_nxt = ost_r;
    oidx_nxt = oidx_r;
    if (out_tvalid && out_tready) ov_nxt = 1'b0;
    if (acc) begin
      case (cmd)
        CMD_LOAD: begin
          if (!full) begin
            if (ok_pos) begin
              // Track length up to the first zero byte.
              if (b == 8'd0) zseen_nxt = 1'b1;
              else if (!zseen_r) zlen_nxt = pos_r + PW'(1);
              pos_nxt = pos_r + PW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_tdata[8]) begin
            ov_nxt = 1'b1; okind_nxt = 1'b0;
            if (full) begin
              ost_nxt = ST_FULL; oidx_nxt = '0;
            end else if (ovf_nxt) begin
              ost_nxt = ST_WORD_BIG; oidx_nxt = 6'(count_r);
            end else begin
              ost_nxt = ST_OK; oidx_nxt = 6'(count_r);
              count_nxt = count_r + CW'(1);
            end
            pos_nxt = '0; ovf_nxt = 1'b0; zseen_nxt = 1'b0;
          end
        end
        CMD_TEXT: begin
          win_nxt = {win_r[MAX_WORD_LEN*8-9:0], fold_upper(b)} ;
          if (tcnt_r < TW'(MAX_TEXT_LEN)) tcnt_nxt = tcnt_r + TW'(1);
        end
        CMD_END: begin
          state_nxt = S_SCAN; scan_nxt = '0;
        end
        CMD_CLEAR: begin
          count_nxt = '0; pos_nxt = '0; ovf_nxt = 1'b0; zseen_nxt = 1'b0;
        end
        default: ;
      endcase
      if (cmd == CMD_LOAD && in_tdata[8]) zlen_nxt = '0;
      if (cmd == CMD_CLEAR) zlen_nxt = '0;
    end
    if (state_r == S_SCAN) begin
      // Walk the cells in index order; stop at the first enabled hit or empty word.
      okind_nxt = 1'b1; oidx_nxt = '0;
      if (tcnt_r == '0) begin
        ost_nxt = ST_EMPTY; ov_nxt = 1'b1; state_nxt = S_RUN;
      end else if (tcnt_r >= TW'(MAX_TEXT_LEN)) begin
        ost_nxt = ST_TOO_LONG; ov_nxt = 1'b1; state_nxt = S_RUN;
      end else if (scan_r >= count_r) begin
        ost_nxt = ST_OK; ov_nxt = 1'b1; state_nxt = S_RUN;
      end else if (lists_r[tagv[sidx]] && (empty[sidx] || hit[sidx])) begin
        ost_nxt = ST_BANNED; oidx_nxt = 6'(scan_r); ov_nxt = 1'b1; state_nxt = S_RUN;
      end else begin
        scan_nxt = scan_r + CW'(1);
      end
      if (state_nxt == S_RUN) begin
        win_nxt = '0; tcnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN; lists_r <= 2'd3; count_r <= '0; pos_r <= '0; ovf_r <= 1'b0;
      zlen_r <= '0; zseen_r <= 1'b0; win_r <= '0; tcnt_r <= '0; scan_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; pos_r <= pos_nxt; ovf_r <= ovf_nxt;
      zlen_r <= zlen_nxt; zseen_r <= zseen_nxt; win_r <= win_nxt; tcnt_r <= tcnt_nxt;
      scan_r <= scan_nxt; ov_r <= ov_nxt;
      if (cfg_we) lists_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    okind_r <= okind_nxt; ost_r <= ost_nxt; oidx_r <= oidx_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tdata  = {7'd0, oidx_r, ost_r};

  // No input beat is taken while a verdict scan runs.
  a_no_acc_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !in_tready) else $error("input taken during scan");
  // An end-of-text beat always leads to the scan state.
  a_end_scan: assert property (@(posedge clk) disable iff (!rst_n)
    acc && cmd == CMD_END |=> state_r == S_SCAN) else $error("end beat lost");
  // The table never grows past its size.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(NUM_WORDS)) else $error("word count overflow");
endmodule

// File: sim/banned_word_substring_filter_test.sv
// Testbench for the banned word substring filter: directed table, then random traffic.
`timescale 1ns / 100ps

module banned_word_substring_filter_test import bwsf_pkg::*; ();

  localparam int NW = NUM_WORDS_D;
  localparam int WL = MAX_WORD_LEN_D;
  localparam int TL = MAX_TEXT_LEN_D;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;

  banned_word_substring_filter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [5:0] index;
  } verdict_t;

  // Shadow copy of the filter state.
  logic [7:0] sh_bytes [NW][WL];
  logic [4:0] sh_len [NW];
  logic       sh_tag [NW];
  int         sh_count;
  int         sh_pos;
  logic       sh_ovf;
  logic [7:0] sh_win [WL];
  int         sh_text;
  logic [NW-1:0] sh_hits;
  logic [1:0] sh_lists;

  verdict_t   pending_q [$];
  int         errors;
  int         mismatches;
  int         beats_sent;
  int         verdicts_seen;
  int         acks_seen;
  int         cycles;
  int         rx_hold;
  bit         hold_long;
  bit         gaps_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic reset_shadow();
    sh_count = 0; sh_pos = 0; sh_ovf = 1'b0; sh_text = 0; sh_hits = '0; sh_lists = 2'd3;
    for (int k = 0; k < WL; k++) sh_win[k] = 8'h00;
  endtask

  // Append one predicted result to the queue of expected results.
  task automatic queue_result(input verdict_t v);
    pending_q = {pending_q, v};
  endtask

  // Advance the shadow by one accepted beat; queue any result it causes.
  task automatic filter_step(input logic [1:0] cmd, input logic [7:0] b, input logic last,
                             input logic tag, input bit have_exp, input verdict_t exp_in);
    verdict_t r;
    logic [7:0] f;
    int n;
    bit same;
    bit full;
    r = '0;
    case (cmd)
      CMD_LOAD: begin
        full = sh_count >= NW;
        if (!full) begin
          if (sh_pos < WL) begin
            sh_bytes[sh_count][sh_pos] = b;
            sh_pos++;
          end else sh_ovf = 1'b1;
        end
        if (last) begin
          r.kind = 1'b0;
          if (full) r.status = ST_FULL;
          else if (sh_ovf) begin
            r.status = ST_WORD_BIG; r.index = sh_count[5:0];
          end else begin
            n = 0;
            while (n < sh_pos && sh_bytes[sh_count][n] != 8'h00) n++;
            sh_len[sh_count] = n[4:0];
            sh_tag[sh_count] = tag;
            r.status = ST_OK; r.index = sh_count[5:0];
            sh_count++;
          end
          sh_pos = 0; sh_ovf = 1'b0;
          queue_result(have_exp ? exp_in : r);
        end
      end
      CMD_TEXT: begin
        f = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
        for (int k = WL - 1; k > 0; k--) sh_win[k] = sh_win[k-1];
        sh_win[0] = f;
        if (sh_text < TL) sh_text++;
        for (int w = 0; w < sh_count; w++) begin
          n = sh_len[w];
          if (n == 0 || n > sh_text) continue;
          same = 1;
          for (int k = 0; k < n; k++)
            if (sh_bytes[w][k] != sh_win[n-1-k]) same = 0;
          if (same) sh_hits[w] = 1'b1;
        end
      end
      CMD_END: begin
        r.kind = 1'b1;
        if (sh_text == 0) r.status = ST_EMPTY;
        else if (sh_text >= TL) r.status = ST_TOO_LONG;
        else begin
          for (int w = 0; w < sh_count; w++) begin
            if (!sh_lists[sh_tag[w]]) continue;
            if (sh_len[w] == 0 || sh_hits[w]) begin
              r.status = ST_BANNED; r.index = w[5:0];
              break;
            end
          end
        end
        for (int k = 0; k < WL; k++) sh_win[k] = 8'h00;
        sh_text = 0; sh_hits = '0;
        queue_result(have_exp ? exp_in : r);
      end
      default: begin
        sh_count = 0; sh_pos = 0; sh_ovf = 1'b0; sh_hits = '0;
      end
    endcase
  endtask

  // Drop valid only when a gap follows; a back-to-back beat keeps it high.
  task automatic idle_gap();
    int g;
    if (!gaps_on) return;
    g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Offer one beat and hold it until taken.
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b, input logic last,
                           input logic tag, input bit have_exp = 0,
                           input verdict_t exp_in = '0);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, tag, last, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    filter_step(cmd, b, last, tag, have_exp, exp_in);
    beats_sent++;
    idle_gap();
  endtask

  task automatic drain_all();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_q.size() != 0) begin
      $display("tb: failure");
      $finish;
    end
    repeat (NW + 8) @(posedge clk);
  endtask

  task automatic write_lists(input logic [1:0] v);
    drain_all();
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_lists = v;
  endtask

  task automatic send_word(input logic [7:0] w [], input logic tag);
    for (int k = 0; k < w.size(); k++)
      send_beat(CMD_LOAD, w[k], k == w.size() - 1, tag);
  endtask

  // Receiver side: random stalls, a few long ones, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold <= 0;
    end else if (hold_long) out_tready <= 1'b0;
    else if (!gaps_on) out_tready <= 1'b1;
    else if (rx_hold != 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      out_tready <= 1'b0;
      rx_hold <= $urandom_range(10, 60);
    end else out_tready <= ($urandom_range(0, 9) < 7) ||
                           ($urandom_range(0, 3) == 0);
  end

  // Compare each taken result with the oldest prediction.
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser; got.status = out_tdata[2:0]; got.index = out_tdata[8:3];
      if (got.kind) verdicts_seen++; else acks_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d status=%0d index=%0d",
                   got.kind, got.status, got.index);
      end else begin
        want = pending_q.pop_front();
        if (got != want || out_tdata[15:9] != '0) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want kind=%0d st=%0d idx=%0d, got kind=%0d st=%0d idx=%0d",
                     want.kind, want.status, want.index, got.kind, got.status, got.index);
        end
      end
    end
  end

  // Directed rows: cmd, byte, last, tag, check flag, typed result.
  typedef struct {
    logic [1:0] cmd;
    logic [7:0] b;
    logic       last;
    logic       tag;
    bit         typed;
    verdict_t   r;
  } row_t;

  row_t rows [] = '{
    '{CMD_END,   8'h00, 1'b0, 1'b0, 1, '{1'b1, ST_EMPTY, 6'd0}},  // empty text
    '{CMD_TEXT,  8'h61, 1'b0, 1'b0, 0, '0},
    '{CMD_END,   8'h00, 1'b0, 1'b0, 1, '{1'b1, ST_OK, 6'd0}},     // no words: accept
    '{CMD_LOAD,  8'h41, 1'b0, 1'b0, 0, '0},
    '{CMD_LOAD,  8'h42, 1'b1, 1'b0, 1, '{1'b0, ST_OK, 6'd0}},     // word AB, chat
    '{CMD_LOAD,  8'h61, 1'b1, 1'b1, 1, '{1'b0, ST_OK, 6'd1}},     // lower-case word
    '{CMD_TEXT,  8'h7A, 1'b0, 1'b0, 0, '0},
    '{CMD_TEXT,  8'h61, 1'b0, 1'b0, 0, '0},
    '{CMD_TEXT,  8'h62, 1'b0, 1'b0, 0, '0},
    '{CMD_END,   8'h00, 1'b0, 1'b0, 1, '{1'b1, ST_BANNED, 6'd0}}, // folded match
    '{CMD_TEXT,  8'h00, 1'b0, 1'b0, 0, '0},                       // zero text byte
    '{CMD_TEXT,  8'hFF, 1'b0, 1'b0, 0, '0},
    '{CMD_END,   8'h00, 1'b0, 1'b0, 0, '0},
    '{CMD_LOAD,  8'h00, 1'b0, 1'b0, 0, '0},                       // empty word
    '{CMD_LOAD,  8'h43, 1'b1, 1'b1, 1, '{1'b0, ST_OK, 6'd2}},
    '{CMD_TEXT,  8'h51, 1'b0, 1'b0, 0, '0},
    '{CMD_END,   8'h00, 1'b0, 1'b0, 1, '{1'b1, ST_BANNED, 6'd2}}, // empty word hits
    '{CMD_LOAD,  8'h58, 1'b0, 1'b0, 0, '0},                       // zero inside word
    '{CMD_LOAD,  8'h00, 1'b0, 1'b0, 0, '0},
    '{CMD_LOAD,  8'h59, 1'b1, 1'b0, 0, '0},
    '{CMD_CLEAR, 8'h00, 1'b0, 1'b0, 0, '0},
    '{CMD_TEXT,  8'h58, 1'b0, 1'b0, 0, '0},
    '{CMD_END,   8'h00, 1'b0, 1'b0, 1, '{1'b1, ST_OK, 6'd0}}      // cleared table
  };

  logic [7:0] wbuf [];

  initial begin
    int kind;
    int n;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    cfg_we = 1'b0; cfg_wdata = 2'd3;
    errors = 0; mismatches = 0; beats_sent = 0; verdicts_seen = 0; acks_seen = 0;
    hold_long = 0; gaps_on = 0;
    reset_shadow();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (rows[i])
      send_beat(rows[i].cmd, rows[i].b, rows[i].last, rows[i].tag, rows[i].typed, rows[i].r);

    // Word too long: one more byte than a slot holds.
    for (int k = 0; k <= WL; k++) send_beat(CMD_LOAD, 8'h41, k == WL, 1'b0);
    // Full-length word, then text too long.
    for (int k = 0; k < WL; k++) send_beat(CMD_LOAD, 8'h5A, k == WL - 1, 1'b1);
    gaps_on = 1;
    for (int k = 0; k < TL; k++) send_beat(CMD_TEXT, 8'h7A, 1'b0, 1'b0);
    send_beat(CMD_END, 8'h00, 1'b0, 1'b0, 1, '{1'b1, ST_TOO_LONG, 6'd0});

    // Sender pause until everything is back, then the register settings.
    write_lists(2'd1);
    send_beat(CMD_TEXT, 8'h5A, 1'b0, 1'b0); send_beat(CMD_END, 8'h00, 1'b0, 1'b0);
    write_lists(2'd2);
    send_beat(CMD_TEXT, 8'h41, 1'b0, 1'b0); send_beat(CMD_END, 8'h00, 1'b0, 1'b0);
    write_lists(2'd0);
    send_beat(CMD_TEXT, 8'h41, 1'b0, 1'b0); send_beat(CMD_END, 8'h00, 1'b0, 1'b0);
    write_lists(2'd3);

    // Fill the table to the limit, then table full.
    send_beat(CMD_CLEAR, 8'h00, 1'b0, 1'b0);
    for (int w = 0; w < NW; w++) send_beat(CMD_LOAD, 8'h30 + w[7:0], 1'b1, w[0]);
    send_beat(CMD_LOAD, 8'h41, 1'b0, 1'b0);
    send_beat(CMD_LOAD, 8'h41, 1'b1, 1'b0, 1, '{1'b0, ST_FULL, 6'd0});

    // Long receiver hold-off while beats keep coming.
    fork
      begin
        hold_long = 1;
        repeat (400) @(posedge clk);
        hold_long = 0;
      end
      begin
        for (int k = 0; k < 12; k++) begin
          send_beat(CMD_TEXT, 8'h30 + k[7:0], 1'b0, 1'b0);
          if (k % 4 == 3) send_beat(CMD_END, 8'h00, 1'b0, 1'b0);
        end
        in_tvalid <= 1'b0;
      end
    join
    send_beat(CMD_CLEAR, 8'h00, 1'b0, 1'b0);

    // Random part: mostly short words and texts built from a small alphabet.
    while (beats_sent < 1220) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(WL, WL + 2) : $urandom_range(1, 4);
        wbuf = new[n];
        foreach (wbuf[k])
          wbuf[k] = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'(8'h41 + $urandom_range(0, 3));
        send_word(wbuf, 1'($urandom_range(0, 1)));
      end else if (kind < 85) begin
        n = $urandom_range(0, 12);
        for (int k = 0; k < n; k++)
          send_beat(CMD_TEXT, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                    : 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 3)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_beat(CMD_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else if (kind < 88) begin
        send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else if (kind < 91) begin
        write_lists(2'($urandom_range(0, 3)));
      end else begin
        send_beat(CMD_TEXT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
    end

    drain_all();
    $display("covered %0d beats: %0d verdicts, %0d load acks, all list settings",
             beats_sent, verdicts_seen, acks_seen);
    $display("including table full, oversize words, overlong text and a long output stall");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d errors", errors);
      $display("tb: failure");
    end
    $finish;
  end
endmodule
